>>> rtl/core/tqbp_pkg.sv
// Shared types, constants and register codes of the ternary quantize and
// bit-plane pack unit. Used by every module in rtl/core; depends on nothing.
package tqbp_pkg;

   localparam int WORD_BITS        = 64;
   localparam int SAMPLE_BITS      = 16;
   localparam int THRESHOLD_BITS   = 15;
   localparam int WORD_IDX_BITS    = $clog2(WORD_BITS);

   localparam int MAX_CHANNELS     = 2048;
   localparam int MAX_ROWS         = 512;
   localparam int MAX_COLUMNS      = 512;
   localparam int MAX_BATCHES      = 256;
   localparam int MAX_WORDS        = (MAX_CHANNELS + WORD_BITS - 1) / WORD_BITS;

   localparam int CHANNEL_REG_BITS = 12;
   localparam int ROW_REG_BITS     = 10;
   localparam int COLUMN_REG_BITS  = 10;
   localparam int PAD_BITS         = 3;
   localparam int BATCH_REG_BITS   = 9;

   localparam int CHAN_POS_BITS    = 11;
   localparam int ROW_POS_BITS     = 9;
   localparam int COL_POS_BITS     = 9;
   localparam int BATCH_POS_BITS   = 8;
   localparam int WORD_SEL_BITS    = CHAN_POS_BITS - WORD_IDX_BITS;
   localparam int PLANE_WORDS_BITS = $clog2(MAX_WORDS + 1);

   localparam int SPAN_BITS        = 10;
   localparam int T1_BITS          = BATCH_POS_BITS + SPAN_BITS + 1;
   localparam int T2_BITS          = T1_BITS + SPAN_BITS + 1;
   localparam int PROD3_BITS       = T2_BITS + PLANE_WORDS_BITS;
   localparam int INDEX_BITS       = 32;

   localparam int CMP_BITS = ((SAMPLE_BITS > THRESHOLD_BITS) ?
                              SAMPLE_BITS : THRESHOLD_BITS) + 2;

   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 12;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CHANNEL_COUNT = 3'd0,
      REG_ROW_COUNT     = 3'd1,
      REG_COLUMN_COUNT  = 3'd2,
      REG_PAD_ROWS      = 3'd3,
      REG_PAD_COLUMNS   = 3'd4,
      REG_BATCH_COUNT   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [CHANNEL_REG_BITS-1:0] channels;
      logic [ROW_REG_BITS-1:0]     rows;
      logic [COLUMN_REG_BITS-1:0]  columns;
      logic [PAD_BITS-1:0]         pad_rows;
      logic [PAD_BITS-1:0]         pad_columns;
      logic [BATCH_REG_BITS-1:0]   batches;
      logic [PLANE_WORDS_BITS-1:0] plane_words;
   } cfg_type;

   typedef struct packed {
      logic                      valid;
      logic [BATCH_POS_BITS-1:0] batch;
      logic [ROW_POS_BITS-1:0]   row;
      logic [COL_POS_BITS-1:0]   column;
      logic [WORD_SEL_BITS-1:0]  word;
      logic [WORD_BITS-1:0]      sign_plane;
      logic [WORD_BITS-1:0]      nonzero_plane;
   } emit_type;

endpackage

>>> rtl/core/tqbp_csr.sv
// Configuration registers of the ternary quantize and bit-plane pack unit,
// with clamping to the legal ranges. Depends on tqbp_pkg.
module tqbp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tqbp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tqbp_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output tqbp_pkg::cfg_type                    cfg
);

   logic [tqbp_pkg::CHANNEL_REG_BITS-1:0] channel_count_ff;
   logic [tqbp_pkg::ROW_REG_BITS-1:0]     row_count_ff;
   logic [tqbp_pkg::COLUMN_REG_BITS-1:0]  column_count_ff;
   logic [tqbp_pkg::PAD_BITS-1:0]         pad_rows_ff;
   logic [tqbp_pkg::PAD_BITS-1:0]         pad_columns_ff;
   logic [tqbp_pkg::BATCH_REG_BITS-1:0]   batch_count_ff;
   logic [tqbp_pkg::CHANNEL_REG_BITS:0]   word_round;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= tqbp_pkg::CHANNEL_REG_BITS'(64);
         row_count_ff     <= tqbp_pkg::ROW_REG_BITS'(1);
         column_count_ff  <= tqbp_pkg::COLUMN_REG_BITS'(1);
         pad_rows_ff      <= '0;
         pad_columns_ff   <= '0;
         batch_count_ff   <= tqbp_pkg::BATCH_REG_BITS'(1);
      end else if (csr_valid) begin
         case (csr_index)
            tqbp_pkg::REG_CHANNEL_COUNT: begin
               channel_count_ff <= csr_data[tqbp_pkg::CHANNEL_REG_BITS-1:0];
            end
            tqbp_pkg::REG_ROW_COUNT: begin
               row_count_ff <= csr_data[tqbp_pkg::ROW_REG_BITS-1:0];
            end
            tqbp_pkg::REG_COLUMN_COUNT: begin
               column_count_ff <= csr_data[tqbp_pkg::COLUMN_REG_BITS-1:0];
            end
            tqbp_pkg::REG_PAD_ROWS: begin
               pad_rows_ff <= csr_data[tqbp_pkg::PAD_BITS-1:0];
            end
            tqbp_pkg::REG_PAD_COLUMNS: begin
               pad_columns_ff <= csr_data[tqbp_pkg::PAD_BITS-1:0];
            end
            tqbp_pkg::REG_BATCH_COUNT: begin
               batch_count_ff <= csr_data[tqbp_pkg::BATCH_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (channel_count_ff == '0) begin
         cfg.channels = tqbp_pkg::CHANNEL_REG_BITS'(1);
      end else if (channel_count_ff >
                   tqbp_pkg::CHANNEL_REG_BITS'(tqbp_pkg::MAX_CHANNELS)) begin
         cfg.channels = tqbp_pkg::CHANNEL_REG_BITS'(tqbp_pkg::MAX_CHANNELS);
      end else begin
         cfg.channels = channel_count_ff;
      end

      if (row_count_ff == '0) begin
         cfg.rows = tqbp_pkg::ROW_REG_BITS'(1);
      end else if (row_count_ff > tqbp_pkg::ROW_REG_BITS'(tqbp_pkg::MAX_ROWS)) begin
         cfg.rows = tqbp_pkg::ROW_REG_BITS'(tqbp_pkg::MAX_ROWS);
      end else begin
         cfg.rows = row_count_ff;
      end

      if (column_count_ff == '0) begin
         cfg.columns = tqbp_pkg::COLUMN_REG_BITS'(1);
      end else if (column_count_ff >
                   tqbp_pkg::COLUMN_REG_BITS'(tqbp_pkg::MAX_COLUMNS)) begin
         cfg.columns = tqbp_pkg::COLUMN_REG_BITS'(tqbp_pkg::MAX_COLUMNS);
      end else begin
         cfg.columns = column_count_ff;
      end

      if (batch_count_ff == '0) begin
         cfg.batches = tqbp_pkg::BATCH_REG_BITS'(1);
      end else if (batch_count_ff >
                   tqbp_pkg::BATCH_REG_BITS'(tqbp_pkg::MAX_BATCHES)) begin
         cfg.batches = tqbp_pkg::BATCH_REG_BITS'(tqbp_pkg::MAX_BATCHES);
      end else begin
         cfg.batches = batch_count_ff;
      end

      cfg.pad_rows    = pad_rows_ff;
      cfg.pad_columns = pad_columns_ff;

      word_round = {1'b0, cfg.channels}
                 + (tqbp_pkg::CHANNEL_REG_BITS+1)'(tqbp_pkg::WORD_BITS - 1);
      cfg.plane_words = tqbp_pkg::PLANE_WORDS_BITS'(word_round >> tqbp_pkg::WORD_IDX_BITS);
   end

endmodule

>>> rtl/core/tqbp_packer.sv
// Ternary quantizer, plane accumulators and loop position counters.
// Produces one packed word per full word or pixel end. Depends on tqbp_pkg.
module tqbp_packer (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_accept,
   input  logic signed [tqbp_pkg::SAMPLE_BITS-1:0]    sample,
   input  logic [tqbp_pkg::THRESHOLD_BITS-1:0]        threshold,
   input  tqbp_pkg::cfg_type                          cfg,
   output tqbp_pkg::emit_type                         emit
);

   logic [tqbp_pkg::CHAN_POS_BITS-1:0]  chan_pos_ff, chan_pos_in;
   logic [tqbp_pkg::COL_POS_BITS-1:0]   col_pos_ff, col_pos_in;
   logic [tqbp_pkg::ROW_POS_BITS-1:0]   row_pos_ff, row_pos_in;
   logic [tqbp_pkg::BATCH_POS_BITS-1:0] batch_pos_ff, batch_pos_in;
   logic [tqbp_pkg::WORD_BITS-1:0]      sign_acc_ff, sign_acc_in;
   logic [tqbp_pkg::WORD_BITS-1:0]      nz_acc_ff, nz_acc_in;

   logic signed [tqbp_pkg::CMP_BITS-1:0] sample_ext, thr_ext, thr_neg;
   logic                                 is_pos, is_neg;
   logic [tqbp_pkg::WORD_IDX_BITS-1:0]   bit_sel;
   logic [tqbp_pkg::WORD_BITS-1:0]       one_hot, sign_next, nz_next;
   logic                                 last_channel, word_full, emit_now;
   logic [tqbp_pkg::CHANNEL_REG_BITS-1:0] chan_inc;
   logic [tqbp_pkg::COL_POS_BITS:0]      col_inc;
   logic [tqbp_pkg::ROW_POS_BITS:0]      row_inc;
   logic [tqbp_pkg::BATCH_POS_BITS:0]    batch_inc;

   always_comb begin
      sample_ext = {{(tqbp_pkg::CMP_BITS - tqbp_pkg::SAMPLE_BITS){sample[tqbp_pkg::SAMPLE_BITS-1]}},
                    sample};
      thr_ext    = {{(tqbp_pkg::CMP_BITS - tqbp_pkg::THRESHOLD_BITS){1'b0}}, threshold};
      thr_neg    = -thr_ext;
      is_pos     = sample_ext > thr_ext;
      is_neg     = sample_ext < thr_neg;

      bit_sel   = chan_pos_ff[tqbp_pkg::WORD_IDX_BITS-1:0];
      one_hot   = tqbp_pkg::WORD_BITS'(1) << bit_sel;
      sign_next = sign_acc_ff | (is_neg ? one_hot : '0);
      nz_next   = nz_acc_ff | ((is_pos || is_neg) ? one_hot : '0);

      chan_inc     = tqbp_pkg::CHANNEL_REG_BITS'(chan_pos_ff) + 1'b1;
      last_channel = chan_inc >= cfg.channels;
      word_full    = bit_sel == tqbp_pkg::WORD_IDX_BITS'(tqbp_pkg::WORD_BITS - 1);
      emit_now     = last_channel || word_full;

      emit.valid         = req_accept && emit_now;
      emit.batch         = batch_pos_ff;
      emit.row           = row_pos_ff;
      emit.column        = col_pos_ff;
      emit.word          = chan_pos_ff[tqbp_pkg::CHAN_POS_BITS-1:tqbp_pkg::WORD_IDX_BITS];
      emit.sign_plane    = sign_next;
      emit.nonzero_plane = nz_next;

      col_inc   = {1'b0, col_pos_ff} + 1'b1;
      row_inc   = {1'b0, row_pos_ff} + 1'b1;
      batch_inc = {1'b0, batch_pos_ff} + 1'b1;

      chan_pos_in  = chan_pos_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      batch_pos_in = batch_pos_ff;
      sign_acc_in  = sign_acc_ff;
      nz_acc_in    = nz_acc_ff;

      if (req_accept) begin
         sign_acc_in = emit_now ? '0 : sign_next;
         nz_acc_in   = emit_now ? '0 : nz_next;
         if (last_channel) begin
            chan_pos_in = '0;
            if (col_inc >= cfg.columns) begin
               col_pos_in = '0;
               if (row_inc >= cfg.rows) begin
                  row_pos_in = '0;
                  if (batch_inc >= cfg.batches) begin
                     batch_pos_in = '0;
                  end else begin
                     batch_pos_in = batch_inc[tqbp_pkg::BATCH_POS_BITS-1:0];
                  end
               end else begin
                  row_pos_in = row_inc[tqbp_pkg::ROW_POS_BITS-1:0];
               end
            end else begin
               col_pos_in = col_inc[tqbp_pkg::COL_POS_BITS-1:0];
            end
         end else begin
            chan_pos_in = chan_inc[tqbp_pkg::CHAN_POS_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff  <= '0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         batch_pos_ff <= '0;
         sign_acc_ff  <= '0;
         nz_acc_ff    <= '0;
      end else begin
         chan_pos_ff  <= chan_pos_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         batch_pos_ff <= batch_pos_in;
         sign_acc_ff  <= sign_acc_in;
         nz_acc_ff    <= nz_acc_in;
      end
   end

`ifndef SYNTHESIS
   a_sign_implies_nonzero: assert property (@(posedge clock) disable iff (reset)
      (sign_acc_ff & ~nz_acc_ff) == '0)
      else $error("sign bit set without its nonzero bit");

   a_full_word_emits: assert property (@(posedge clock) disable iff (reset)
      (req_accept && word_full) |-> emit.valid)
      else $error("full word did not produce a transaction");

   a_emit_clears_acc: assert property (@(posedge clock) disable iff (reset)
      emit.valid |=> (sign_acc_ff == '0 && nz_acc_ff == '0))
      else $error("accumulators not cleared after an emitted word");

   a_pixel_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_channel) |=> chan_pos_ff == '0)
      else $error("channel position did not wrap at pixel end");
`endif

endmodule

>>> rtl/core/tqbp_index_pipe.sv
// Padded NHWC cell index pipeline: input register, then one multiply per
// stage to the result register; per-stage elastic valids. Depends on tqbp_pkg.
module tqbp_index_pipe (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tqbp_pkg::cfg_type                      cfg,
   input  tqbp_pkg::emit_type                     emit,
   output logic                                   in_ready,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tqbp_pkg::INDEX_BITS-1:0]        rsp_cell_index,
   output logic [tqbp_pkg::WORD_BITS-1:0]         rsp_sign_plane,
   output logic [tqbp_pkg::WORD_BITS-1:0]         rsp_nonzero_plane
);

   logic                                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                                 rdy1, rdy2, rdy3, rdy4;
   logic [tqbp_pkg::BATCH_POS_BITS-1:0]  b1_ff;
   logic [tqbp_pkg::ROW_POS_BITS-1:0]    r1_ff;
   logic [tqbp_pkg::COL_POS_BITS-1:0]    c1_ff, c2_ff;
   logic [tqbp_pkg::WORD_SEL_BITS-1:0]   w1_ff, w2_ff, w3_ff;
   logic [tqbp_pkg::WORD_BITS-1:0]       s1_ff, s2_ff, s3_ff, s4_ff;
   logic [tqbp_pkg::WORD_BITS-1:0]       n1_ff, n2_ff, n3_ff, n4_ff;
   logic [tqbp_pkg::T1_BITS-1:0]         t1_ff, t1_in;
   logic [tqbp_pkg::T2_BITS-1:0]         t2_ff, t2_in;
   logic [tqbp_pkg::INDEX_BITS-1:0]      idx_ff, idx_in;
   logic [tqbp_pkg::SPAN_BITS-1:0]       ph, pw;
   logic [tqbp_pkg::PROD3_BITS-1:0]      prod3;

   assign rdy4     = !v4_ff || !rsp_stall;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      ph = tqbp_pkg::SPAN_BITS'(cfg.rows) + tqbp_pkg::SPAN_BITS'({cfg.pad_rows, 1'b0});
      pw = tqbp_pkg::SPAN_BITS'(cfg.columns) + tqbp_pkg::SPAN_BITS'({cfg.pad_columns, 1'b0});
      t1_in = tqbp_pkg::T1_BITS'(b1_ff) * tqbp_pkg::T1_BITS'(ph)
            + tqbp_pkg::T1_BITS'(r1_ff) + tqbp_pkg::T1_BITS'(cfg.pad_rows);
      t2_in = tqbp_pkg::T2_BITS'(t1_ff) * tqbp_pkg::T2_BITS'(pw)
            + tqbp_pkg::T2_BITS'(c2_ff) + tqbp_pkg::T2_BITS'(cfg.pad_columns);
      prod3  = tqbp_pkg::PROD3_BITS'(t2_ff) * tqbp_pkg::PROD3_BITS'(cfg.plane_words);
      idx_in = prod3[tqbp_pkg::INDEX_BITS-1:0] + tqbp_pkg::INDEX_BITS'(w3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= emit.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         b1_ff <= emit.batch;
         r1_ff <= emit.row;
         c1_ff <= emit.column;
         w1_ff <= emit.word;
         s1_ff <= emit.sign_plane;
         n1_ff <= emit.nonzero_plane;
      end
      if (rdy2) begin
         t1_ff <= t1_in;
         c2_ff <= c1_ff;
         w2_ff <= w1_ff;
         s2_ff <= s1_ff;
         n2_ff <= n1_ff;
      end
      if (rdy3) begin
         t2_ff <= t2_in;
         w3_ff <= w2_ff;
         s3_ff <= s2_ff;
         n3_ff <= n2_ff;
      end
      if (rdy4) begin
         idx_ff <= idx_in;
         s4_ff  <= s3_ff;
         n4_ff  <= n3_ff;
      end
   end

   assign rsp_valid         = v4_ff;
   assign rsp_cell_index    = idx_ff;
   assign rsp_sign_plane    = s4_ff;
   assign rsp_nonzero_plane = n4_ff;

endmodule

>>> rtl/core/ternary_quantize_bitplane_pack_unit.sv
// Top level of the ternary quantize and bit-plane pack unit.
// Instantiates tqbp_csr, tqbp_packer and tqbp_index_pipe; uses tqbp_pkg.
//
// Usage:
//   The req channel takes one activation sample per transaction, in loop
//   order batch, row, column, channel innermost, with the threshold of its
//   batch item. The rsp channel returns one packed word pair per full word
//   of 64 channels and per pixel end, with its padded NHWC cell index.
//   The csr channel writes the six configuration registers by index; it is
//   always ready and must only be used while no result is outstanding.
//   Throughput is one sample per cycle while req_stall is low. A result
//   transaction is presented on rsp once the word closed by a sample has
//   been registered in turn by the input register and three index stages,
//   each index stage holding one multiplier.
//   Reset clears all loop positions and accumulators, empties the pipeline
//   and restores the register defaults.
//   When the receiver stalls, the result holds on rsp, the index stages
//   keep filling their empty slots, and req_stall rises once the stage that
//   takes new words is occupied and cannot advance.
module ternary_quantize_bitplane_pack_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [tqbp_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic [tqbp_pkg::THRESHOLD_BITS-1:0]       req_threshold,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [tqbp_pkg::INDEX_BITS-1:0]           rsp_cell_index,
   output logic [tqbp_pkg::WORD_BITS-1:0]            rsp_sign_plane,
   output logic [tqbp_pkg::WORD_BITS-1:0]            rsp_nonzero_plane,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tqbp_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [tqbp_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   tqbp_pkg::cfg_type  cfg;
   tqbp_pkg::emit_type emit;
   logic               in_ready;
   logic               req_accept;

   assign req_stall  = !in_ready;
   assign req_accept = req_valid && in_ready;

   tqbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tqbp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .sample     (req_sample),
      .threshold  (req_threshold),
      .cfg        (cfg),
      .emit       (emit)
   );

   tqbp_index_pipe u_index_pipe (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .emit              (emit),
      .in_ready          (in_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_sign_plane    (rsp_sign_plane),
      .rsp_nonzero_plane (rsp_nonzero_plane)
   );

endmodule
